[hw/rtl/rlc_pkg.sv]
// Shared types, constants and tables of the square-arena lidar ray caster.
package rlc_pkg;

  // Field and register widths.
  localparam int COORD_W     = 16;
  localparam int ANGLE_W     = 16;
  localparam int RANGE_W     = 13;
  localparam int BCNT_W      = 7;
  localparam int IDX_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_BEAMS   = 64;
  localparam int QUEUE_DEPTH = 4;

  // Register reset values.
  localparam logic [BCNT_W-1:0]  BEAM_CNT_RST  = 7'd20;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 13'd5039;
  localparam logic [RANGE_W-1:0] HALF_RST      = 13'd1536;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BEAM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_HALF = 2'd2;

  // One beam handed from the front to the back.
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [ANGLE_W-1:0]        ang;
    logic [IDX_W-1:0]          idx;
    logic                      last;
  } beam_t;

  // Whole part of one turn divided by the beam count, indexed by count minus one.
  localparam logic [16:0] STEP_TBL [MAX_BEAMS] = '{
    17'(65536/1),  17'(65536/2),  17'(65536/3),  17'(65536/4),
    17'(65536/5),  17'(65536/6),  17'(65536/7),  17'(65536/8),
    17'(65536/9),  17'(65536/10), 17'(65536/11), 17'(65536/12),
    17'(65536/13), 17'(65536/14), 17'(65536/15), 17'(65536/16),
    17'(65536/17), 17'(65536/18), 17'(65536/19), 17'(65536/20),
    17'(65536/21), 17'(65536/22), 17'(65536/23), 17'(65536/24),
    17'(65536/25), 17'(65536/26), 17'(65536/27), 17'(65536/28),
    17'(65536/29), 17'(65536/30), 17'(65536/31), 17'(65536/32),
    17'(65536/33), 17'(65536/34), 17'(65536/35), 17'(65536/36),
    17'(65536/37), 17'(65536/38), 17'(65536/39), 17'(65536/40),
    17'(65536/41), 17'(65536/42), 17'(65536/43), 17'(65536/44),
    17'(65536/45), 17'(65536/46), 17'(65536/47), 17'(65536/48),
    17'(65536/49), 17'(65536/50), 17'(65536/51), 17'(65536/52),
    17'(65536/53), 17'(65536/54), 17'(65536/55), 17'(65536/56),
    17'(65536/57), 17'(65536/58), 17'(65536/59), 17'(65536/60),
    17'(65536/61), 17'(65536/62), 17'(65536/63), 17'(65536/64)
  };

  // Horner coefficients of the quarter-turn sine, innermost first after 11.
  localparam logic [17:0] SIN_INIT = 18'd11;
  localparam logic [17:0] SIN_COEF [4] = '{18'd307, 18'd5223, 18'd42333, 18'd102944};

endpackage

[hw/rtl/rlc_front.sv]
// Front end: accepts a pose and issues one beam record per cycle while the queue is not full.
module rlc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rlc_pkg::BCNT_W-1:0]    beam_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [rlc_pkg::COORD_W-1:0] in_pose_x,
  input  logic signed [rlc_pkg::COORD_W-1:0] in_pose_y,
  input  logic [rlc_pkg::ANGLE_W-1:0]   in_heading,
  output logic                          push,
  output rlc_pkg::beam_t                push_item,
  input  logic                          full
);
  import rlc_pkg::*;

  logic                      busy_r, busy_nxt;
  logic signed [COORD_W-1:0] px_r, py_r;
  logic [ANGLE_W-1:0]        head_r;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [BCNT_W-1:0]         n_r, n_nxt;
  logic [16:0]               q_r, q_nxt;
  logic [BCNT_W-1:0]         r_r, r_nxt;
  logic [16:0]               stq_r, stq_nxt;
  logic [BCNT_W-1:0]         str_r, str_nxt;
  logic                      accept, last;
  logic [BCNT_W-1:0]         n_eff, r_sum;
  logic [23:0]               qn;

  // Beam count with zero raised to one and large counts saturated.
  always_comb begin
    if (beam_count == '0) begin
      n_eff = BCNT_W'(1);
    end else if (beam_count > BCNT_W'(MAX_BEAMS)) begin
      n_eff = BCNT_W'(MAX_BEAMS);
    end else begin
      n_eff = beam_count;
    end
  end

  assign qn      = 24'(STEP_TBL[IDX_W'(n_eff - 1'b1)]) * 24'(n_eff);
  assign last    = ({1'b0, idx_r} + 7'd1) == n_r;
  assign push    = busy_r && !full;
  assign in_ready = !busy_r || (push && last);
  assign accept  = in_valid && in_ready;
  assign r_sum   = r_r + str_r;

  assign push_item.px   = px_r;
  assign push_item.py   = py_r;
  assign push_item.ang  = head_r + q_r[ANGLE_W-1:0];
  assign push_item.idx  = idx_r;
  assign push_item.last = last;

  // Beam angle accumulator: quotient and remainder of i turns over n.
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    stq_nxt  = stq_r;
    str_nxt  = str_r;
    if (push) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (r_sum >= n_r) begin
          r_nxt = r_sum - n_r;
          q_nxt = q_r + stq_r + 17'd1;
        end else begin
          r_nxt = r_sum;
          q_nxt = q_r + stq_r;
        end
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      n_nxt    = n_eff;
      q_nxt    = '0;
      r_nxt    = '0;
      stq_nxt  = STEP_TBL[IDX_W'(n_eff - 1'b1)];
      str_nxt  = BCNT_W'(24'd65536 - qn);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Pose and step registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    stq_r <= stq_nxt;
    str_r <= str_nxt;
    if (accept) begin
      px_r   <= in_pose_x;
      py_r   <= in_pose_y;
      head_r <= in_heading;
    end
  end

endmodule

[hw/rtl/rlc_fifo.sv]
// Short queue of beam records between the front and the back.
module rlc_fifo #(
  parameter int DEPTH = rlc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rlc_pkg::beam_t push_item,
  output logic           full,
  input  logic           pop,
  output rlc_pkg::beam_t head,
  output logic           nonempty
);
  import rlc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  beam_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign nonempty = cnt_r != '0;
  assign head     = mem[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

endmodule

[hw/rtl/rlc_back.sv]
// Back end: sine/cosine, ray deltas, wall tests, nearest hit and distance divide.
module rlc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rlc_pkg::RANGE_W-1:0]   max_range,
  input  logic [rlc_pkg::RANGE_W-1:0]   arena_half,
  input  logic                          q_valid,
  input  rlc_pkg::beam_t                q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rlc_pkg::RANGE_W-1:0]   out_range_out,
  output logic [rlc_pkg::IDX_W-1:0]     out_beam_index,
  output logic                          out_last_beam
);
  import rlc_pkg::*;

  localparam int DIV_STEPS = RANGE_W;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic                      vld;
    tag_t                      tag;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [1:0]                quad;
    logic [1:0][16:0]          x;
    logic [1:0][16:0]          x2;
    logic [1:0][17:0]          p;
  } poly_t;

  typedef struct packed {
    logic                      vld;
    tag_t                      tag;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [1:0]                quad;
    logic [1:0][16:0]          sn;
  } sin_t;

  typedef struct packed {
    logic                      vld;
    tag_t                      tag;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [29:0]               pc;
    logic [29:0]               ps;
    logic                      c_neg;
    logic                      s_neg;
  } scl_t;

  typedef struct packed {
    logic                     vld;
    tag_t                     tag;
    logic signed [13:0]       rdx;
    logic signed [13:0]       rdy;
    logic [3:0][COORD_W:0]    ox;
    logic [3:0][COORD_W:0]    oy;
  } ray_t;

  typedef struct packed {
    logic                   vld;
    tag_t                   tag;
    logic [3:0][30:0]       cp1;
    logic [3:0][30:0]       cp2;
    logic [3:0][26:0]       dlim;
    logic [3:0][COORD_W:0]  t0;
    logic [3:0][12:0]       d;
    logic [3:0]             dneg;
    logic [3:0]             dzero;
  } prod_t;

  typedef struct packed {
    logic             vld;
    tag_t             tag;
    logic [3:0]       hit;
    logic [3:0][12:0] t;
    logic [3:0][12:0] d;
  } hit_t;

  typedef struct packed {
    logic             vld;
    tag_t             tag;
    logic [3:0]       hit;
    logic [3:0][12:0] t;
    logic [3:0][12:0] d;
    logic [1:0][25:0] m0;
    logic [1:0][25:0] m1;
  } cmp4_t;

  typedef struct packed {
    logic             vld;
    tag_t             tag;
    logic [1:0]       hit;
    logic [1:0][12:0] t;
    logic [1:0][12:0] d;
  } best2_t;

  typedef struct packed {
    logic             vld;
    tag_t             tag;
    logic [1:0]       hit;
    logic [1:0][12:0] t;
    logic [1:0][12:0] d;
    logic [25:0]      m0;
    logic [25:0]      m1;
  } cmp2_t;

  typedef struct packed {
    logic        vld;
    tag_t        tag;
    logic        hit;
    logic [12:0] t;
    logic [12:0] d;
  } best_t;

  typedef struct packed {
    logic        vld;
    tag_t        tag;
    logic        hit;
    logic [12:0] rem;
    logic [12:0] low;
    logic [12:0] d;
  } div_t;

  logic   adv;
  poly_t  pl_r [5];
  poly_t  pl_nxt [5];
  sin_t   sn_r, sn_nxt;
  scl_t   sc_r, sc_nxt;
  ray_t   ry_r, ry_nxt;
  prod_t  pr_r, pr_nxt;
  hit_t   ht_r, ht_nxt;
  cmp4_t  c4_r, c4_nxt;
  best2_t b2_r, b2_nxt;
  cmp2_t  c2_r, c2_nxt;
  best_t  bt_r, bt_nxt;
  div_t   dv_r [DIV_STEPS+1];
  div_t   dv_nxt [DIV_STEPS+1];
  logic   out_valid_r;
  logic [RANGE_W-1:0] out_range_r;
  tag_t   out_tag_r;

  // The whole pipeline moves when the output register is free or drained.
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  // Quarter-turn fraction and its complement, squared.
  always_comb begin
    logic [16:0] xa, xb;
    logic [33:0] sqa, sqb;
    xa = {1'b0, q_item.ang[ANGLE_W-3:0], 2'b00};
    xb = 17'd65536 - xa;
    sqa = 34'(xa) * 34'(xa);
    sqb = 34'(xb) * 34'(xb);
    pl_nxt[0].vld   = q_valid;
    pl_nxt[0].tag   = '{idx: q_item.idx, last: q_item.last};
    pl_nxt[0].px    = q_item.px;
    pl_nxt[0].py    = q_item.py;
    pl_nxt[0].quad  = q_item.ang[ANGLE_W-1:ANGLE_W-2];
    pl_nxt[0].x[0]  = xa;
    pl_nxt[0].x[1]  = xb;
    pl_nxt[0].x2[0] = sqa[32:16];
    pl_nxt[0].x2[1] = sqb[32:16];
    pl_nxt[0].p[0]  = SIN_INIT;
    pl_nxt[0].p[1]  = SIN_INIT;
  end

  // Horner steps, one multiply per stage in each lane.
  for (genvar j = 1; j < 5; j++) begin : g_horner
    always_comb begin
      logic [34:0] hp0, hp1;
      hp0 = 35'(pl_r[j-1].p[0]) * 35'(pl_r[j-1].x2[0]);
      hp1 = 35'(pl_r[j-1].p[1]) * 35'(pl_r[j-1].x2[1]);
      pl_nxt[j] = pl_r[j-1];
      pl_nxt[j].p[0] = SIN_COEF[j-1] - hp0[33:16];
      pl_nxt[j].p[1] = SIN_COEF[j-1] - hp1[33:16];
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_poly_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pl_r[j].vld <= 1'b0;
      end else if (adv) begin
        pl_r[j] <= pl_nxt[j];
      end
    end
  end

  // Final multiply by x and clamp to one.
  always_comb begin
    logic [34:0] fa, fb;
    fa = 35'(pl_r[4].p[0]) * 35'(pl_r[4].x[0]);
    fb = 35'(pl_r[4].p[1]) * 35'(pl_r[4].x[1]);
    sn_nxt.vld  = pl_r[4].vld;
    sn_nxt.tag  = pl_r[4].tag;
    sn_nxt.px   = pl_r[4].px;
    sn_nxt.py   = pl_r[4].py;
    sn_nxt.quad = pl_r[4].quad;
    sn_nxt.sn[0] = (fa[34:16] > 19'd65536) ? 17'd65536 : fa[32:16];
    sn_nxt.sn[1] = (fb[34:16] > 19'd65536) ? 17'd65536 : fb[32:16];
  end

  // Quadrant selection and scaling of the unit direction by the range.
  always_comb begin
    logic [16:0] cm, sm;
    case (sn_r.quad)
      2'd0: begin
        sm = sn_r.sn[0];
        cm = sn_r.sn[1];
      end
      2'd1: begin
        sm = sn_r.sn[1];
        cm = sn_r.sn[0];
      end
      2'd2: begin
        sm = sn_r.sn[0];
        cm = sn_r.sn[1];
      end
      default: begin
        sm = sn_r.sn[1];
        cm = sn_r.sn[0];
      end
    endcase
    sc_nxt.vld   = sn_r.vld;
    sc_nxt.tag   = sn_r.tag;
    sc_nxt.px    = sn_r.px;
    sc_nxt.py    = sn_r.py;
    sc_nxt.pc    = 30'(max_range) * 30'(cm);
    sc_nxt.ps    = 30'(max_range) * 30'(sm);
    sc_nxt.s_neg = sn_r.quad[1];
    sc_nxt.c_neg = sn_r.quad == 2'd1 || sn_r.quad == 2'd2;
  end

  // Rounded ray deltas and the pose offsets from each wall's start corner.
  always_comb begin
    logic [29:0] rc, rs;
    logic signed [COORD_W:0] pxe, pye, he;
    rc  = sc_r.pc + 30'd32768;
    rs  = sc_r.ps + 30'd32768;
    pxe = (COORD_W+1)'(sc_r.px);
    pye = (COORD_W+1)'(sc_r.py);
    he  = (COORD_W+1)'({1'b0, arena_half});
    ry_nxt.vld = sc_r.vld;
    ry_nxt.tag = sc_r.tag;
    ry_nxt.rdx = sc_r.c_neg ? -$signed(rc[29:16]) : $signed(rc[29:16]);
    ry_nxt.rdy = sc_r.s_neg ? -$signed(rs[29:16]) : $signed(rs[29:16]);
    ry_nxt.ox[0] = pxe + he;
    ry_nxt.oy[0] = pye + he;
    ry_nxt.ox[1] = pxe - he;
    ry_nxt.oy[1] = pye + he;
    ry_nxt.ox[2] = pxe - he;
    ry_nxt.oy[2] = pye - he;
    ry_nxt.ox[3] = pxe + he;
    ry_nxt.oy[3] = pye - he;
  end

  // Per-wall products: cross terms and the bound on the wall parameter.
  always_comb begin
    logic signed [13:0]      dl;
    logic signed [COORD_W:0] ox, oy;
    logic [12:0]             dm;
    pr_nxt.vld = ry_r.vld;
    pr_nxt.tag = ry_r.tag;
    for (int w = 0; w < 4; w++) begin
      ox = $signed(ry_r.ox[w]);
      oy = $signed(ry_r.oy[w]);
      dl = (w == 0 || w == 2) ? ry_r.rdy : ry_r.rdx;
      dm = dl[13] ? 13'(-dl) : dl[12:0];
      pr_nxt.cp1[w]   = 31'(ox * ry_r.rdy);
      pr_nxt.cp2[w]   = 31'(oy * ry_r.rdx);
      pr_nxt.dlim[w]  = 27'({arena_half, 1'b0}) * 27'(dm);
      pr_nxt.t0[w]    = (w == 0 || w == 2) ? oy : ox;
      pr_nxt.d[w]     = dm;
      pr_nxt.dneg[w]  = dl[13];
      pr_nxt.dzero[w] = dl == '0;
    end
  end

  // Segment test with inclusive bounds on both parameters.
  always_comb begin
    logic signed [32:0]      cc, uu;
    logic signed [COORD_W+1:0] tt;
    logic                    flip;
    ht_nxt.vld = pr_r.vld;
    ht_nxt.tag = pr_r.tag;
    for (int w = 0; w < 4; w++) begin
      cc   = 33'($signed(pr_r.cp1[w])) - 33'($signed(pr_r.cp2[w]));
      flip = (w == 1 || w == 2) ^ pr_r.dneg[w];
      uu   = flip ? -cc : cc;
      tt   = pr_r.dneg[w] ? -(COORD_W+2)'($signed(pr_r.t0[w]))
                          : (COORD_W+2)'($signed(pr_r.t0[w]));
      ht_nxt.hit[w] = !pr_r.dzero[w] && arena_half != '0 && !tt[COORD_W+1] &&
                      tt[COORD_W:0] <= (COORD_W+1)'(pr_r.d[w]) &&
                      !uu[32] && uu[31:0] <= 32'(pr_r.dlim[w]);
      ht_nxt.t[w] = tt[12:0];
      ht_nxt.d[w] = pr_r.d[w];
    end
  end

  // First level of the nearest-hit search: cross products of wall pairs.
  always_comb begin
    c4_nxt.vld = ht_r.vld;
    c4_nxt.tag = ht_r.tag;
    c4_nxt.hit = ht_r.hit;
    c4_nxt.t   = ht_r.t;
    c4_nxt.d   = ht_r.d;
    for (int k = 0; k < 2; k++) begin
      c4_nxt.m0[k] = 26'(ht_r.t[2*k]) * 26'(ht_r.d[2*k+1]);
      c4_nxt.m1[k] = 26'(ht_r.t[2*k+1]) * 26'(ht_r.d[2*k]);
    end
  end

  always_comb begin
    logic first;
    b2_nxt.vld = c4_r.vld;
    b2_nxt.tag = c4_r.tag;
    for (int k = 0; k < 2; k++) begin
      first = c4_r.hit[2*k] && (!c4_r.hit[2*k+1] || c4_r.m0[k] < c4_r.m1[k]);
      b2_nxt.hit[k] = c4_r.hit[2*k] || c4_r.hit[2*k+1];
      b2_nxt.t[k]   = first ? c4_r.t[2*k] : c4_r.t[2*k+1];
      b2_nxt.d[k]   = first ? c4_r.d[2*k] : c4_r.d[2*k+1];
    end
  end

  // Second level of the search.
  always_comb begin
    c2_nxt.vld = b2_r.vld;
    c2_nxt.tag = b2_r.tag;
    c2_nxt.hit = b2_r.hit;
    c2_nxt.t   = b2_r.t;
    c2_nxt.d   = b2_r.d;
    c2_nxt.m0  = 26'(b2_r.t[0]) * 26'(b2_r.d[1]);
    c2_nxt.m1  = 26'(b2_r.t[1]) * 26'(b2_r.d[0]);
  end

  always_comb begin
    logic first;
    first = c2_r.hit[0] && (!c2_r.hit[1] || c2_r.m0 < c2_r.m1);
    bt_nxt.vld = c2_r.vld;
    bt_nxt.tag = c2_r.tag;
    bt_nxt.hit = c2_r.hit[0] || c2_r.hit[1];
    bt_nxt.t   = first ? c2_r.t[0] : c2_r.t[1];
    bt_nxt.d   = first ? c2_r.d[0] : c2_r.d[1];
  end

  // Dividend is range times numerator; the quotient fits the range width.
  always_comb begin
    logic [25:0] num;
    num = 26'(max_range) * 26'(bt_r.t);
    dv_nxt[0].vld = bt_r.vld;
    dv_nxt[0].tag = bt_r.tag;
    dv_nxt[0].hit = bt_r.hit;
    dv_nxt[0].rem = num[25:13];
    dv_nxt[0].low = num[12:0];
    dv_nxt[0].d   = bt_r.d;
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    always_comb begin
      logic [13:0] tr;
      logic        ge;
      tr = {dv_r[j-1].rem, dv_r[j-1].low[12]};
      ge = tr >= {1'b0, dv_r[j-1].d};
      dv_nxt[j]     = dv_r[j-1];
      dv_nxt[j].rem = ge ? 13'(tr - {1'b0, dv_r[j-1].d}) : tr[12:0];
      dv_nxt[j].low = {dv_r[j-1].low[11:0], ge};
    end
  end

  for (genvar j = 0; j <= DIV_STEPS; j++) begin : g_div_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j].vld <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // Stage registers between the sine and the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_r.vld <= 1'b0;
      sc_r.vld <= 1'b0;
      ry_r.vld <= 1'b0;
      pr_r.vld <= 1'b0;
      ht_r.vld <= 1'b0;
      c4_r.vld <= 1'b0;
      b2_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
      bt_r.vld <= 1'b0;
    end else if (adv) begin
      sn_r <= sn_nxt;
      sc_r <= sc_nxt;
      ry_r <= ry_nxt;
      pr_r <= pr_nxt;
      ht_r <= ht_nxt;
      c4_r <= c4_nxt;
      b2_r <= b2_nxt;
      c2_r <= c2_nxt;
      bt_r <= bt_nxt;
    end
  end

  // Output register: a miss reports the full range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[DIV_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_range_r <= dv_r[DIV_STEPS].hit ? dv_r[DIV_STEPS].low : max_range;
      out_tag_r   <= dv_r[DIV_STEPS].tag;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_range_out  = out_range_r;
  assign out_beam_index = out_tag_r.idx;
  assign out_last_beam  = out_tag_r.last;

endmodule

[hw/rtl/lidar_ray_cast_square_arena_top.sv]
// Top level of the square-arena lidar ray caster.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_ready | in_pose_x, in_pose_y, in_heading
//   out_    | output    | out_valid/out_ready | out_range_out, out_beam_index, out_last_beam
//   cfg_    | input     | cfg_we            | cfg_index, cfg_data
//
// The front issues one beam per cycle while the queue is not full (a count of zero gives
// one beam, counts above 64 give 64), and the next pose is taken in the cycle its last
// beam is issued.
// Each beam then passes through the back pipeline (sine, scaling, wall tests,
// two-level nearest-hit search and a 13-stage divider) before reaching the output.
// Reset is synchronous and active low; it clears control state and loads register defaults.
// A stalled output freezes the back pipeline; the queue lets the front keep issuing.
module lidar_ray_cast_square_arena_top #(
  parameter int QUEUE_DEPTH = rlc_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rlc_pkg::COORD_W-1:0]   in_pose_x,
  input  logic signed [rlc_pkg::COORD_W-1:0]   in_pose_y,
  input  logic [rlc_pkg::ANGLE_W-1:0]          in_heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rlc_pkg::RANGE_W-1:0]          out_range_out,
  output logic [rlc_pkg::IDX_W-1:0]            out_beam_index,
  output logic                                 out_last_beam,
  input  logic                                 cfg_we,
  input  logic [rlc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rlc_pkg::RANGE_W-1:0]          cfg_data
);
  import rlc_pkg::*;

  logic [BCNT_W-1:0]  beam_count_r;
  logic [RANGE_W-1:0] max_range_r;
  logic [RANGE_W-1:0] half_r;
  logic               push, full, pop, nonempty;
  beam_t              push_item, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_count_r <= BEAM_CNT_RST;
      max_range_r  <= MAX_RANGE_RST;
      half_r       <= HALF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BEAM_COUNT: beam_count_r <= cfg_data[BCNT_W-1:0];
        CFG_MAX_RANGE:  max_range_r  <= cfg_data;
        CFG_ARENA_HALF: half_r       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rlc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .beam_count(beam_count_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pose_x (in_pose_x),
    .in_pose_y (in_pose_y),
    .in_heading(in_heading),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  rlc_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  rlc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .max_range     (max_range_r),
    .arena_half    (half_r),
    .q_valid       (nonempty),
    .q_item        (head),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_range_out (out_range_out),
    .out_beam_index(out_beam_index),
    .out_last_beam (out_last_beam)
  );

endmodule
